FILE: src/mpt_pkg.sv
package mpt_pkg;

  localparam int COL_W       = 7;
  localparam int ROW_W       = 5;
  localparam int BTN_W       = 3;
  localparam int BYTE_W      = 8;
  localparam int DELTA_W     = 9;
  localparam int ACC_W       = 10;
  localparam int MAG_W       = 9;
  localparam int REM_W       = 4;
  localparam int POS_SUM_W   = 11;
  localparam int SENS_W      = 5;
  localparam int DIV_STEPS   = 9;
  localparam int DIV_CNT_W   = 4;
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = 1;
  localparam int Q_CNT_W     = 2;

  localparam logic [SENS_W-1:0] SENS_RESET = 5'd8;
  localparam logic [SENS_W-1:0] SENS_MIN   = 5'd1;
  localparam logic [SENS_W-1:0] SENS_MAX   = 5'd16;

  // PS/2 status byte bits
  localparam int STAT_VALID_BIT = 3;
  localparam int STAT_XSIGN_BIT = 4;
  localparam int STAT_YSIGN_BIT = 5;

  localparam logic ACT_PS2_BYTE  = 1'b0;
  localparam logic ACT_USB_REPORT = 1'b1;

  typedef struct packed {
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic                      dy_up;
    logic [BTN_W-1:0]          buttons;
  } motion_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_UPD
  } back_state_t;

endpackage

FILE: src/mpt_if.sv
interface mpt_in_if;
  logic              valid;
  logic              ready;
  logic              action;
  logic [7:0]        data_byte;
  logic [7:0]        report_buttons;
  logic signed [7:0] report_dx;
  logic signed [7:0] report_dy;

  modport source (output valid, action, data_byte, report_buttons, report_dx, report_dy,
                  input ready);
  modport sink   (input valid, action, data_byte, report_buttons, report_dx, report_dy,
                  output ready);
endinterface

interface mpt_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] cursor_col;
  logic [4:0] cursor_row;
  logic [2:0] button_bits;

  modport source (output valid, cursor_col, cursor_row, button_bits, input ready);
  modport sink   (input valid, cursor_col, cursor_row, button_bits, output ready);
endinterface

interface mpt_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: src/mpt_front.sv
module mpt_front
  import mpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  mpt_in_if.sink      in_ch,
  input  q_status_t   q_status,
  output logic        push,
  output motion_cmd_t push_cmd
);

  logic [1:0]        byte_phase_r, byte_phase_nxt;
  logic [BYTE_W-1:0] held_r [2];
  logic              accept;

  assign in_ch.ready = !q_status.full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    byte_phase_nxt = byte_phase_r;
    push           = 1'b0;
    push_cmd       = '0;
    if (accept) begin
      if (in_ch.action == ACT_USB_REPORT) begin
        push             = 1'b1;
        push_cmd.dx      = DELTA_W'(in_ch.report_dx);
        push_cmd.dy      = DELTA_W'(in_ch.report_dy);
        push_cmd.dy_up   = 1'b0;
        push_cmd.buttons = in_ch.report_buttons[BTN_W-1:0];
      end else if (!byte_phase_r[1]) begin
        byte_phase_nxt = byte_phase_r + 2'd1;
      end else begin
        // third byte (phase three behaves the same)
        byte_phase_nxt   = 2'd0;
        push             = held_r[0][STAT_VALID_BIT];
        push_cmd.dx      = {held_r[0][STAT_XSIGN_BIT], held_r[1]};
        push_cmd.dy      = {held_r[0][STAT_YSIGN_BIT], in_ch.data_byte};
        push_cmd.dy_up   = 1'b1;
        push_cmd.buttons = held_r[0][BTN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_phase_r <= 2'd0;
    end else begin
      byte_phase_r <= byte_phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_ch.action == ACT_PS2_BYTE && !byte_phase_r[1]) begin
      held_r[byte_phase_r[0]] <= in_ch.data_byte;
    end
  end

endmodule

FILE: src/mpt_fifo.sv
module mpt_fifo
  import mpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  motion_cmd_t push_cmd,
  input  logic        pop,
  output motion_cmd_t pop_cmd,
  output q_status_t   status
);

  motion_cmd_t         mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]  count_r;

  assign status.full  = (count_r == Q_CNT_W'(Q_DEPTH));
  assign status.empty = (count_r == '0);
  assign pop_cmd      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_r + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && status.full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && status.empty))
    else $error("pop from empty queue");

endmodule

FILE: src/mpt_back.sv
module mpt_back
  import mpt_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SENS_W-1:0] sens,
  input  q_status_t         q_status,
  input  motion_cmd_t       pop_cmd,
  output logic              pop,
  mpt_out_if.source         out_ch
);

  localparam logic signed [POS_SUM_W-1:0] COL_MAX = POS_SUM_W'(COLUMNS - 1);
  localparam logic signed [POS_SUM_W-1:0] ROW_MAX = POS_SUM_W'(ROWS - 1);

  back_state_t                  state_r, state_nxt;
  logic signed [ACC_W-1:0]      acc_x_r, acc_y_r;
  logic [COL_W-1:0]             pos_col_r;
  logic [ROW_W-1:0]             pos_row_r;
  logic [BTN_W-1:0]             buttons_r;
  logic                         out_valid_r;
  logic [DIV_CNT_W-1:0]         cnt_r;
  logic [MAG_W-1:0]             dvd_x_r, dvd_y_r;
  logic [REM_W-1:0]             rem_x_r, rem_y_r;
  logic                         neg_x_r, neg_y_r, dy_up_r;
  logic [BTN_W-1:0]             cmd_btn_r;

  logic signed [ACC_W-1:0]      sum_x, sum_y;
  logic [ACC_W-1:0]             abs_x, abs_y;
  logic [REM_W:0]               trial_x, trial_y, sub_x, sub_y;
  logic                         ge_x, ge_y;
  logic signed [ACC_W-1:0]      q_x, q_y, r_x, r_y;
  logic signed [POS_SUM_W-1:0]  col_sum, row_sum, row_step;
  logic                         slot_free, do_upd;

  assign sum_x = acc_x_r + ACC_W'(pop_cmd.dx);
  assign sum_y = acc_y_r + ACC_W'(pop_cmd.dy);
  assign abs_x = sum_x[ACC_W-1] ? ACC_W'(-sum_x) : ACC_W'(sum_x);
  assign abs_y = sum_y[ACC_W-1] ? ACC_W'(-sum_y) : ACC_W'(sum_y);

  // one restoring step per cycle, both axes side by side
  assign trial_x = {rem_x_r, dvd_x_r[MAG_W-1]};
  assign trial_y = {rem_y_r, dvd_y_r[MAG_W-1]};
  assign ge_x    = (trial_x >= sens);
  assign ge_y    = (trial_y >= sens);
  assign sub_x   = trial_x - sens;
  assign sub_y   = trial_y - sens;

  // truncation toward zero: quotient and remainder take the dividend's sign
  assign q_x = neg_x_r ? -ACC_W'(dvd_x_r) : ACC_W'(dvd_x_r);
  assign q_y = neg_y_r ? -ACC_W'(dvd_y_r) : ACC_W'(dvd_y_r);
  assign r_x = neg_x_r ? -ACC_W'(rem_x_r) : ACC_W'(rem_x_r);
  assign r_y = neg_y_r ? -ACC_W'(rem_y_r) : ACC_W'(rem_y_r);

  assign row_step = dy_up_r ? -POS_SUM_W'(q_y) : POS_SUM_W'(q_y);
  assign col_sum  = POS_SUM_W'(signed'({1'b0, pos_col_r})) + POS_SUM_W'(q_x);
  assign row_sum  = POS_SUM_W'(signed'({1'b0, pos_row_r})) + row_step;

  assign slot_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    do_upd    = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_status.empty) begin
          pop       = 1'b1;
          state_nxt = B_DIV;
        end
      end
      B_DIV: begin
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) state_nxt = B_UPD;
      end
      B_UPD: begin
        if (slot_free) begin
          do_upd    = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      acc_x_r     <= '0;
      acc_y_r     <= '0;
      pos_col_r   <= '0;
      pos_row_r   <= '0;
      buttons_r   <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (pop) cnt_r <= '0;
      else if (state_r == B_DIV) cnt_r <= cnt_r + 1'b1;
      if (do_upd) begin
        acc_x_r     <= r_x;
        acc_y_r     <= r_y;
        buttons_r   <= cmd_btn_r;
        out_valid_r <= 1'b1;
        priority if (col_sum < 0)       pos_col_r <= '0;
        else if (col_sum > COL_MAX)     pos_col_r <= COL_W'(COL_MAX);
        else                            pos_col_r <= COL_W'(col_sum);
        priority if (row_sum < 0)       pos_row_r <= '0;
        else if (row_sum > ROW_MAX)     pos_row_r <= ROW_W'(ROW_MAX);
        else                            pos_row_r <= ROW_W'(row_sum);
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      dvd_x_r   <= abs_x[MAG_W-1:0];
      dvd_y_r   <= abs_y[MAG_W-1:0];
      rem_x_r   <= '0;
      rem_y_r   <= '0;
      neg_x_r   <= sum_x[ACC_W-1];
      neg_y_r   <= sum_y[ACC_W-1];
      dy_up_r   <= pop_cmd.dy_up;
      cmd_btn_r <= pop_cmd.buttons;
    end else if (state_r == B_DIV) begin
      dvd_x_r <= {dvd_x_r[MAG_W-2:0], ge_x};
      dvd_y_r <= {dvd_y_r[MAG_W-2:0], ge_y};
      rem_x_r <= ge_x ? sub_x[REM_W-1:0] : trial_x[REM_W-1:0];
      rem_y_r <= ge_y ? sub_y[REM_W-1:0] : trial_y[REM_W-1:0];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.cursor_col  = pos_col_r;
  assign out_ch.cursor_row  = pos_row_r;
  assign out_ch.button_bits = buttons_r;

  a_div_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_DIV |-> cnt_r < DIV_CNT_W'(DIV_STEPS))
    else $error("divider step count out of range");

  a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == B_UPD))
    else $error("result raised outside update");

endmodule

FILE: src/mouse_packet_position_tracker.sv
// A motion item leaves the queue, goes through the 9 divider steps and then the
// update state, which waits for a free output slot before the result is registered.
// The back end's 9-step restoring divider works on one motion item at a time;
// the queue takes input until full, PS/2 bytes that complete no packet included.
// Reset (rst_n low, synchronous) clears byte phase, accumulators, position,
// buttons and the queue, and sets sensitivity to 8; no clearing pass.
module mouse_packet_position_tracker
  import mpt_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic       clk,
  input  logic       rst_n,
  mpt_in_if.sink     in_ch,
  mpt_out_if.source  out_ch,
  mpt_cfg_if.sink    cfg_ch
);

  logic [SENS_W-1:0] sens_r;
  logic              push, pop;
  motion_cmd_t       push_cmd, pop_cmd;
  q_status_t         q_status;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_r <= SENS_RESET;
    end else if (cfg_ch.valid) begin
      priority if (cfg_ch.data < SENS_MIN) sens_r <= SENS_MIN;
      else if (cfg_ch.data > SENS_MAX)     sens_r <= SENS_MAX;
      else                                 sens_r <= cfg_ch.data;
    end
  end

  mpt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_status (q_status),
    .push     (push),
    .push_cmd (push_cmd)
  );

  mpt_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .status   (q_status)
  );

  mpt_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .sens     (sens_r),
    .q_status (q_status),
    .pop_cmd  (pop_cmd),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

FILE: tb/sv/mpt_tracker_checker.sv
module mpt_tracker_checker
  import mpt_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic clk,
  input  logic rst_n,
  mpt_in_if    in_mon,
  mpt_out_if   out_mon,
  mpt_cfg_if   cfg_mon,
  output int   fail_count,
  output int   pending,
  output int   checked_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [BTN_W-1:0] buttons;
  } cursor_report_t;

  cursor_report_t    cursor_q[$];
  logic [SENS_W-1:0] sens;
  logic [1:0]        byte_phase;
  logic [BYTE_W-1:0] held_status;
  logic [BYTE_W-1:0] held_x;
  int                acc_x;
  int                acc_y;
  int                cur_col;
  int                cur_row;
  logic [BTN_W-1:0]  btn_state;

  function automatic int clamp_cell(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // quotient moves the cursor, signed remainder stays behind (SV / and % truncate to zero)
  task automatic move_cursor(int dx, int dy, bit row_up);
    int div;
    int q_row;
    div = int'(sens);
    acc_x += dx;
    acc_y += dy;
    cur_col = clamp_cell(cur_col + acc_x / div, COLUMNS - 1);
    q_row   = acc_y / div;
    cur_row = clamp_cell(row_up ? cur_row - q_row : cur_row + q_row, ROWS - 1);
    acc_x   = acc_x % div;
    acc_y   = acc_y % div;
  endtask

  task automatic track_input();
    int dx;
    int dy;
    if (in_mon.action == ACT_USB_REPORT) begin
      move_cursor(int'($signed(in_mon.report_dx)), int'($signed(in_mon.report_dy)), 1'b0);
      btn_state = in_mon.report_buttons[BTN_W-1:0];
      cursor_q.push_back({COL_W'(cur_col), ROW_W'(cur_row), btn_state});
    end else if (byte_phase == 2'd0) begin
      held_status = in_mon.data_byte;
      byte_phase  = 2'd1;
    end else if (byte_phase == 2'd1) begin
      held_x     = in_mon.data_byte;
      byte_phase = 2'd2;
    end else begin
      byte_phase = 2'd0;
      if (held_status[STAT_VALID_BIT]) begin
        dx = int'(held_x);
        dy = int'(in_mon.data_byte);
        if (held_status[STAT_XSIGN_BIT]) dx -= 256;
        if (held_status[STAT_YSIGN_BIT]) dy -= 256;
        move_cursor(dx, dy, 1'b1);
        btn_state = held_status[BTN_W-1:0];
        cursor_q.push_back({COL_W'(cur_col), ROW_W'(cur_row), btn_state});
      end
    end
  endtask

  task automatic check_cursor();
    cursor_report_t want;
    cursor_report_t got;
    got = {out_mon.cursor_col, out_mon.cursor_row, out_mon.button_bits};
    if (cursor_q.size() == 0) begin
      $display("%0t: unexpected cursor update col=%0d row=%0d buttons=%0d",
               $time, got.col, got.row, got.buttons);
      fail_count++;
    end else begin
      want = cursor_q.pop_front();
      checked_count++;
      if (got !== want) begin
        $display("%0t: cursor mismatch expected col=%0d row=%0d buttons=%0d, got col=%0d row=%0d buttons=%0d",
                 $time, want.col, want.row, want.buttons, got.col, got.row, got.buttons);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cursor_q.delete();
      sens          = SENS_RESET;
      byte_phase    = 2'd0;
      held_status   = '0;
      held_x        = '0;
      acc_x         = 0;
      acc_y         = 0;
      cur_col       = 0;
      cur_row       = 0;
      btn_state     = '0;
      fail_count    = 0;
      checked_count = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) check_cursor();
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.data < SENS_MIN) sens = SENS_MIN;
        else if (cfg_mon.data > SENS_MAX) sens = SENS_MAX;
        else sens = cfg_mon.data;
      end
      if (in_mon.valid && in_mon.ready) track_input();
    end
    pending = cursor_q.size();
  end

endmodule

FILE: tb/sv/tb.sv
module tb
  import mpt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_COLS         = 80;
  localparam int GRID_ROWS         = 25;
  localparam int IDLE_LIMIT        = 3000;
  localparam int SETTLE_CYCLES     = 16;
  localparam int ITEMS_PER_SETTING = 190;

  logic clk = 1'b0;
  logic rst_n;

  mpt_in_if  in_ch ();
  mpt_out_if out_ch ();
  mpt_cfg_if cfg_ch ();

  int fail_count;
  int pending;
  int checked_count;
  int n_items = 0;
  int n_usb   = 0;
  int n_cfg   = 0;
  int ps2_phase = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit no_idle = 1'b0;

  logic [SENS_W-1:0] sens_plan [7] = '{5'd0, 5'd16, 5'd31, 5'd1, 5'd5, 5'd20, 5'd11};

  always #6 clk = ~clk;

  mouse_packet_position_tracker #(
    .COLUMNS (GRID_COLS),
    .ROWS    (GRID_ROWS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  mpt_tracker_checker #(
    .COLUMNS (GRID_COLS),
    .ROWS    (GRID_ROWS)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .cfg_mon       (cfg_ch),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count)
  );

  // mostly short gaps, now and then a long one; none during busy stretches
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic put_item(input logic act, input logic [7:0] byte_val, input logic [7:0] btn,
                          input logic [7:0] dx, input logic [7:0] dy);
    int gap;
    @(negedge clk);
    in_ch.valid          = 1'b1;
    in_ch.action         = act;
    in_ch.data_byte      = byte_val;
    in_ch.report_buttons = btn;
    in_ch.report_dx      = dx;
    in_ch.report_dy      = dy;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    n_items++;
    if (act == ACT_USB_REPORT) n_usb++;
    else ps2_phase = (ps2_phase + 1) % 3;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid          = 1'b0;
      in_ch.action         = 1'($urandom);
      in_ch.data_byte      = 8'($urandom);
      in_ch.report_buttons = 8'($urandom);
      in_ch.report_dx      = 8'($urandom);
      in_ch.report_dy      = 8'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic put_byte(input logic [7:0] b);
    put_item(ACT_PS2_BYTE, b, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic put_report(input logic [7:0] btn, input logic [7:0] dx, input logic [7:0] dy);
    put_item(ACT_USB_REPORT, 8'($urandom), btn, dx, dy);
  endtask

  task automatic put_packet(input logic [7:0] status, input logic [7:0] x, input logic [7:0] y);
    put_byte(status);
    put_byte(x);
    put_byte(y);
  endtask

  // 9-bit PS/2 motion: sign goes to the status byte, low byte to the data byte
  function automatic logic [8:0] ps2_motion();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 9'($urandom_range(0, 80) - 40);
    if (r < 85) return 9'($urandom);
    return $urandom_range(0, 1) ? 9'h0FF : 9'h100;
  endfunction

  function automatic logic [7:0] usb_motion();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 8'($urandom_range(0, 40) - 20);
    if (r < 90) return 8'($urandom);
    return $urandom_range(0, 1) ? 8'h7F : 8'h80;
  endfunction

  task automatic random_traffic(input int count);
    int k;
    int r;
    logic [8:0] mx;
    logic [8:0] my;
    logic [7:0] status;
    k = 0;
    while (k < count) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        // realign first if a stray byte left a partial packet behind
        while (ps2_phase != 0) begin
          put_byte(8'($urandom));
          k++;
        end
        mx     = ps2_motion();
        my     = ps2_motion();
        status = 8'($urandom);
        status[STAT_VALID_BIT] = ($urandom_range(0, 9) != 0);
        status[STAT_XSIGN_BIT] = mx[8];
        status[STAT_YSIGN_BIT] = my[8];
        put_packet(status, mx[7:0], my[7:0]);
        k += 3;
      end else if (r < 90) begin
        put_report(8'($urandom), usb_motion(), usb_motion());
        k++;
      end else begin
        put_byte(8'($urandom));
        k++;
      end
    end
  endtask

  // let every expected update drain, plus room for a dropped packet still in flight
  task automatic quiesce(input int cycles);
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (cycles) @(negedge clk);
  endtask

  task automatic write_sens(input logic [SENS_W-1:0] v);
    quiesce(SETTLE_CYCLES);
    cfg_ch.valid = 1'b1;
    cfg_ch.data  = v;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    n_cfg++;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = 5'($urandom);
  endtask

  initial begin
    forever begin
      no_idle = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(100, 400)) @(posedge clk);
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else begin
        out_ch.ready = 1'b1;
        if ($urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.action         = ACT_PS2_BYTE;
    in_ch.data_byte      = '0;
    in_ch.report_buttons = '0;
    in_ch.report_dx      = '0;
    in_ch.report_dy      = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.data          = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part at the reset sensitivity
    put_report(8'hFF, 8'h7F, 8'h7F);
    put_report(8'h00, 8'h80, 8'h80);
    put_packet(8'h0F, 8'hFF, 8'h00);
    put_packet(8'h38, 8'h00, 8'h00);   // both sign bits, largest negative motion
    put_packet(8'h07, 8'h55, 8'hAA);   // valid bit clear: dropped
    put_packet(8'hFF, 8'h80, 8'h7F);
    // USB report in the middle of a PS/2 packet leaves the byte count alone
    put_byte(8'h28);
    put_report(8'h05, 8'h03, 8'hFD);
    put_byte(8'h10);
    put_byte(8'hF0);
    put_report(8'h02, 8'h7F, 8'h7F);
    put_report(8'h02, 8'h7F, 8'h7F);
    put_report(8'h04, 8'h80, 8'h80);

    random_traffic(ITEMS_PER_SETTING);
    for (int i = 0; i < 7; i++) begin
      write_sens((i == 6) ? 5'($urandom) : sens_plan[i]);
      random_traffic(ITEMS_PER_SETTING);
    end

    quiesce(40);
    $display("covered %0d input transfers (%0d USB reports), %0d cursor updates checked",
             n_items, n_usb, checked_count);
    $display("sensitivity written %0d times, clamped low and high values included", n_cfg);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/mpt_pkg.sv
src/mpt_if.sv
src/mpt_front.sv
src/mpt_fifo.sv
src/mpt_back.sv
src/mouse_packet_position_tracker.sv
tb/sv/mpt_tracker_checker.sv
tb/sv/tb.sv
